>>> design/pdi_pkg.sv
`timescale 1ns / 1ps
// Package for the pattern dictionary indexer.
// Holds default sizes, field widths and the control bundle for the cell row.
// It depends on nothing else.
package pdi_pkg;

    localparam int DICT_DEPTH_DEF   = 256;
    localparam int PATTERN_BITS_DEF = 64;

    localparam int PATTERN_W      = 64;
    localparam int INDEX_W        = 8;
    localparam int UNIQUE_COUNT_W = 9;
    localparam int S_TDATA_W      = 64;
    localparam int M_TDATA_W      = 24;
    localparam int M_TUSER_W      = 2;

    localparam int M_TUSER_IS_NEW   = 0;
    localparam int M_TUSER_OVERFLOW = 1;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        logic wr_en;
    } cell_ctrl_t;

endpackage

>>> design/pdi_cell.sv
`timescale 1ns / 1ps
// One dictionary cell: a stored pattern, its comparator and one stage of the
// match shift line. Uses the control bundle from pdi_pkg.
module pdi_cell #(
    parameter int PATTERN_BITS = pdi_pkg::PATTERN_BITS_DEF
) (
    input  logic                    aclk,
    input  pdi_pkg::cell_ctrl_t     ctrl,
    input  logic                    wr_sel,
    input  logic [PATTERN_BITS-1:0] pattern,
    input  logic                    match_in,
    output logic                    match_out
);

    logic [PATTERN_BITS-1:0] entry_reg;
    logic                    match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && wr_sel) begin
            entry_reg <= pattern;
        end
        if (ctrl.cmp_en) begin
            match_reg <= (entry_reg == pattern);
        end else if (ctrl.shift_en) begin
            match_reg <= match_in;
        end
    end

    assign match_out = match_reg;

endmodule

>>> design/pdi_chain.sv
`timescale 1ns / 1ps
// Row of dictionary cells with the write select decode.
// Instantiates pdi_cell and uses the control bundle from pdi_pkg.
module pdi_chain #(
    parameter int DICT_DEPTH   = pdi_pkg::DICT_DEPTH_DEF,
    parameter int PATTERN_BITS = pdi_pkg::PATTERN_BITS_DEF,
    localparam int IDX_W       = $clog2(DICT_DEPTH)
) (
    input  logic                    aclk,
    input  pdi_pkg::cell_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic [PATTERN_BITS-1:0] pattern,
    output logic                    match_head
);

    logic [DICT_DEPTH:0] match_chain;

    assign match_chain[DICT_DEPTH] = 1'b0;
    assign match_head              = match_chain[0];

    for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
        pdi_cell #(
            .PATTERN_BITS(PATTERN_BITS)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .wr_sel   (wr_addr == IDX_W'(i)),
            .pattern  (pattern),
            .match_in (match_chain[i+1]),
            .match_out(match_chain[i])
        );
    end

endmodule

>>> design/pattern_dictionary_indexer.sv
`timescale 1ns / 1ps
// Pattern dictionary indexer: looks up each pattern in a dictionary built in
// order of first appearance. Instantiates pdi_chain and uses pdi_pkg.
//
// Each pattern is compared against every stored entry at once in a row of
// cells; the match flags then shift out of the row one cell per cycle while a
// counter tracks the index, stopping at the first hit or at the fill count.
// The scan visits the entries before a hit, or every current entry on a miss,
// and so never more than DICT_DEPTH. The next input transfer is accepted only
// once the previous result is registered, so items never overlap in the block.
// A new item is taken while the previous result still waits on the output. A
// start flag on a transfer empties the dictionary before its pattern is
// handled; the store needs no clearing after reset.
module pattern_dictionary_indexer #(
    parameter int DICT_DEPTH   = pdi_pkg::DICT_DEPTH_DEF,
    parameter int PATTERN_BITS = pdi_pkg::PATTERN_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pdi_pkg::S_TDATA_W-1:0] s_tdata,   // pattern[63:0]
    input  logic                          s_tuser,   // start_of_set
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pdi_pkg::M_TDATA_W-1:0] m_tdata,   // index[7:0], unique_count[16:8], zeros
    output logic [pdi_pkg::M_TUSER_W-1:0] m_tuser    // is_new[0], overflow[1]
);

    localparam int CNT_W = $clog2(DICT_DEPTH + 1);
    localparam int IDX_W = $clog2(DICT_DEPTH);
    localparam int EXT_W = CNT_W + pdi_pkg::UNIQUE_COUNT_W;
    localparam int PAD_W = pdi_pkg::M_TDATA_W - pdi_pkg::INDEX_W - pdi_pkg::UNIQUE_COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             scan_reg;
    logic [PATTERN_BITS-1:0]      pat_reg;
    logic [CNT_W-1:0]             res_idx_reg;
    logic                         res_new_reg;
    logic                         res_ovf_reg;
    logic                         m_tvalid_reg;
    logic [pdi_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [pdi_pkg::M_TUSER_W-1:0] m_tuser_reg;

    pdi_pkg::cell_ctrl_t          cell_ctrl;
    logic                         match_head;
    logic                         out_free;
    logic                         emit;
    logic [CNT_W-1:0]             count_next;
    logic [EXT_W-1:0]             idx_ext;
    logic [EXT_W-1:0]             cnt_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (state_reg == ST_EMIT) && out_free;

    assign count_next = count_reg + CNT_W'(res_new_reg);
    assign idx_ext    = EXT_W'(res_idx_reg);
    assign cnt_ext    = EXT_W'(count_next);

    always_comb begin
        cell_ctrl.cmp_en   = (state_reg == ST_LOAD);
        cell_ctrl.shift_en = (state_reg == ST_SCAN);
        cell_ctrl.wr_en    = emit && res_new_reg;
    end

    pdi_chain #(
        .DICT_DEPTH  (DICT_DEPTH),
        .PATTERN_BITS(PATTERN_BITS)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (cell_ctrl),
        .wr_addr   (count_reg[IDX_W-1:0]),
        .pattern   (pat_reg),
        .match_head(match_head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            res_new_reg  <= 1'b0;
            res_ovf_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !emit) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pat_reg   <= s_tdata[PATTERN_BITS-1:0];
                        if (s_tuser) begin
                            count_reg <= '0;
                        end
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    scan_reg  <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_reg == count_reg) begin
                        res_idx_reg <= (count_reg == CNT_W'(DICT_DEPTH)) ? '0 : count_reg;
                        res_new_reg <= (count_reg != CNT_W'(DICT_DEPTH));
                        res_ovf_reg <= (count_reg == CNT_W'(DICT_DEPTH));
                        state_reg <= ST_EMIT;
                    end else if (match_head) begin
                        res_idx_reg <= scan_reg;
                        res_new_reg <= 1'b0;
                        res_ovf_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end else begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{PAD_W{1'b0}},
                                         cnt_ext[pdi_pkg::UNIQUE_COUNT_W-1:0],
                                         idx_ext[pdi_pkg::INDEX_W-1:0]};
                        m_tuser_reg[pdi_pkg::M_TUSER_IS_NEW]   <= res_new_reg;
                        m_tuser_reg[pdi_pkg::M_TUSER_OVERFLOW] <= res_ovf_reg;
                        count_reg    <= count_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DICT_DEPTH))
        else $error("Entry count exceeds the dictionary depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && res_ovf_reg |-> !res_new_reg && res_idx_reg == '0
                                && count_reg == CNT_W'(DICT_DEPTH))
        else $error("Overflow result is inconsistent with a full dictionary.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && res_new_reg |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("New entry did not advance the entry count.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_reg <= count_reg)
        else $error("Scan ran past the filled part of the dictionary.");

endmodule

>>> tb/pdi_lookup_checker.sv
`timescale 1ns / 1ps
// Checker for the pattern dictionary indexer: watches both stream channels, predicts each
// result from the accepted input transfers and compares it field by field. Uses pdi_pkg.
module pdi_lookup_checker #(
    parameter int DICT_DEPTH   = pdi_pkg::DICT_DEPTH_DEF,
    parameter int PATTERN_BITS = pdi_pkg::PATTERN_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [pdi_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pdi_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [pdi_pkg::M_TUSER_W-1:0] m_tuser,
    output int                            mismatch_count,
    output int                            outstanding
);
    import pdi_pkg::*;

    localparam logic [PATTERN_W-1:0] PATTERN_MASK =
        (PATTERN_BITS >= PATTERN_W) ? '1 : ((64'd1 << PATTERN_BITS) - 64'd1);

    typedef struct packed {
        logic [INDEX_W-1:0]        index;
        logic                      is_new;
        logic                      overflow;
        logic [UNIQUE_COUNT_W-1:0] unique_count;
    } lookup_result_t;

    logic [PATTERN_W-1:0] dict_store [DICT_DEPTH];
    int                   stored;
    lookup_result_t       pending_lookups [$];

    function automatic lookup_result_t predict_lookup(input logic [PATTERN_W-1:0] raw,
                                                      input logic start);
        logic [PATTERN_W-1:0] pat;
        int                   hit;
        lookup_result_t       res;
        pat = raw & PATTERN_MASK;
        hit = -1;
        res = '0;
        if (start) begin
            stored = 0;
        end
        for (int k = 0; k < stored; k++) begin
            if (hit < 0 && dict_store[k] == pat) begin
                hit = k;
            end
        end
        if (hit >= 0) begin
            res.index = INDEX_W'(hit);
        end else if (stored < DICT_DEPTH) begin
            dict_store[stored] = pat;
            res.index = INDEX_W'(stored);
            res.is_new = 1'b1;
            stored++;
        end else begin
            res.overflow = 1'b1;
        end
        res.unique_count = UNIQUE_COUNT_W'(stored);
        return res;
    endfunction

    always @(posedge aclk) begin
        lookup_result_t want;
        lookup_result_t got;
        if (!aresetn) begin
            stored = 0;
            pending_lookups.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.index        = m_tdata[INDEX_W-1:0];
                got.unique_count = m_tdata[INDEX_W +: UNIQUE_COUNT_W];
                got.is_new       = m_tuser[M_TUSER_IS_NEW];
                got.overflow     = m_tuser[M_TUSER_OVERFLOW];
                if (pending_lookups.size() == 0) begin
                    $error("Result transfer arrived with no prediction waiting.");
                    mismatch_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (got.index != want.index) begin
                        $error("index: expected %0d, actual %0d", want.index, got.index);
                        mismatch_count++;
                    end
                    if (got.is_new != want.is_new) begin
                        $error("is_new: expected %0d, actual %0d", want.is_new, got.is_new);
                        mismatch_count++;
                    end
                    if (got.overflow != want.overflow) begin
                        $error("overflow: expected %0d, actual %0d", want.overflow,
                               got.overflow);
                        mismatch_count++;
                    end
                    if (got.unique_count != want.unique_count) begin
                        $error("unique_count: expected %0d, actual %0d", want.unique_count,
                               got.unique_count);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_lookups.insert(pending_lookups.size(),
                                       predict_lookup(s_tdata, s_tuser));
            end
        end
        outstanding = pending_lookups.size();
    end

endmodule

>>> tb/tb_pattern_dictionary_indexer.sv
`timescale 1ns / 1ps
// Top level of the pattern dictionary indexer testbench: clock, reset, stimulus and verdict.
// Depends on pdi_pkg, pattern_dictionary_indexer and pdi_lookup_checker.
module tb_pattern_dictionary_indexer;
    import pdi_pkg::*;

    localparam int DEPTH       = DICT_DEPTH_DEF;
    localparam int PAT_BITS    = PATTERN_BITS_DEF;
    localparam int ITEM_TARGET = 2000;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 8000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int   mismatch_count;
    int   outstanding;
    int   items_sent   = 0;
    int   quiet_cycles = 0;
    bit   gaps_on      = 1'b1;
    bit   hold_request = 1'b0;

    pattern_dictionary_indexer #(
        .DICT_DEPTH  (DEPTH),
        .PATTERN_BITS(PAT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    pdi_lookup_checker #(
        .DICT_DEPTH  (DEPTH),
        .PATTERN_BITS(PAT_BITS)
    ) lookup_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !(gaps_on && $urandom_range(99) < 24);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_pattern(input logic [PATTERN_W-1:0] pat, input logic start);
        while (gaps_on && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pat;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    initial begin
        logic [PATTERN_W-1:0] pat;
        logic [PATTERN_W-1:0] seen [$];
        int                   fill_sets;
        int                   set_len;
        int                   r;
        fill_sets = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pattern(64'h0123_4567_89AB_CDEF, 1'b0);
        send_pattern(64'h0, 1'b0);
        send_pattern('1, 1'b0);
        send_pattern(64'h0, 1'b0);
        send_pattern(64'h5555_5555_5555_5555, 1'b0);
        send_pattern(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_pattern('1, 1'b0);
        send_pattern(64'h0123_4567_89AB_CDEF, 1'b0);
        send_pattern('1, 1'b1);
        send_pattern(64'h0, 1'b0);
        send_pattern(64'h8000_0000_0000_0000, 1'b0);
        send_pattern(64'h1, 1'b0);
        send_pattern(64'h0, 1'b0);
        send_pattern('1, 1'b0);
        send_pattern(64'h0, 1'b1);
        send_pattern(64'h0, 1'b1);
        send_pattern(64'h8000_0000_0000_0000, 1'b0);

        hold_request = 1'b1;
        repeat (12) send_pattern({$urandom(), $urandom()}, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            if (fill_sets < 3 &&
                ($urandom_range(9) == 0 || items_sent > 600 * (fill_sets + 1))) begin
                // The first full set runs with no idling on either side.
                gaps_on = (fill_sets != 0);
                seen.delete();
                for (int i = 0; i < DEPTH; i++) begin
                    pat = {$urandom(), $urandom()};
                    pat[15:0] = 16'(i);
                    send_pattern(pat, i == 0);
                    seen.insert(seen.size(), pat);
                end
                send_pattern(seen[DEPTH-1], 1'b0);
                send_pattern(seen[0], 1'b0);
                repeat (24) begin
                    if ($urandom_range(1) == 1) begin
                        send_pattern({$urandom(), $urandom()}, 1'b0);
                    end else begin
                        send_pattern(seen[$urandom_range(DEPTH - 1)], 1'b0);
                    end
                end
                gaps_on = 1'b1;
                fill_sets++;
            end else begin
                set_len = $urandom_range(1, 40);
                seen.delete();
                for (int j = 0; j < set_len; j++) begin
                    r = $urandom_range(99);
                    if (r < 45 && seen.size() != 0) begin
                        pat = seen[$urandom_range(seen.size() - 1)];
                    end else if (r < 55) begin
                        case ($urandom_range(2))
                            0:       pat = '0;
                            1:       pat = '1;
                            default: pat = 64'h1 << $urandom_range(63);
                        endcase
                    end else begin
                        pat = {$urandom(), $urandom()};
                    end
                    send_pattern(pat, (j == 0) ? ($urandom_range(9) != 0)
                                               : ($urandom_range(49) == 0));
                    seen.insert(seen.size(), pat);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
